/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the baud divisor search RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define FBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/fbd_pkg.sv */
// ----------------------------------------------------------------------------
// fbd_pkg
// Types and constants of the fractional baud divisor search.
// ----------------------------------------------------------------------------
package fbd_pkg;

    localparam int PORT_W     = 2;
    localparam int BAUD_W     = 22;
    localparam int CLK_W      = 28;
    localparam int SEL_W      = 8;
    localparam int ACC_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;
    localparam int DL_W       = 17;
    localparam int MV_W       = 4;
    localparam int PCT_W      = 8;

    localparam int DIV_NUM_W  = 60;   // (pclk * mul) << 28
    localparam int DIV_DEN_W  = 27;   // baud * (mul + divadd)
    localparam int DIV_STEPS  = DIV_NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CLK_W-1:0] CORE_CLK_RESET = 28'd100000000;
    localparam logic [SEL_W-1:0] SEL_RESET      = 8'h00;
    localparam logic [ACC_W-1:0] ACC_RESET      = 7'd3;

    localparam logic [MV_W-1:0]  MUL_MAX        = 4'd15;
    localparam logic [31:0]      HALF_FRAC      = 32'h8000_0000;
    localparam logic [31:0]      ERR_INIT       = 32'hFFFF_FFFF;
    localparam logic [28:0]      LATCH_MAX      = 29'd65536;
    localparam logic [6:0]       PCT_SCALE      = 7'd100;
    localparam logic [PCT_W-1:0] PCT_SAT        = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORE_CLK = 2'd0,
        CFG_DIV_SEL  = 2'd1,
        CFG_ACC_ERR  = 2'd2,
        CFG_NONE     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PCLK_DIV4 = 2'd0,
        PCLK_DIV1 = 2'd1,
        PCLK_DIV2 = 2'd2,
        PCLK_DIV8 = 2'd3
    } t_pclk_sel;

    typedef struct packed {
        logic load;
        logic start_pair;
        logic eval;
        logic start_rate;
        logic start_pct;
        logic load_res;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic last_pair;
        logic exact_now;
        logic found;
        logic baud_zero;
    } t_dp_stat;

endpackage

/* rtl/fbd_in_if.sv */
// ----------------------------------------------------------------------------
// fbd_in_if
// Request channel: port number and target baud rate.
// ----------------------------------------------------------------------------
interface fbd_in_if;
    logic                       valid;
    logic                       ready;
    logic [fbd_pkg::PORT_W-1:0] port_number;
    logic [fbd_pkg::BAUD_W-1:0] baud_rate;

    modport source (output valid, port_number, baud_rate, input ready);
    modport sink   (input valid, port_number, baud_rate, output ready);
endinterface

/* rtl/fbd_out_if.sv */
// ----------------------------------------------------------------------------
// fbd_out_if
// Result channel: chosen divisor settings and baud error.
// ----------------------------------------------------------------------------
interface fbd_out_if;
    logic                      valid;
    logic                      ready;
    logic                      success;
    logic [fbd_pkg::DL_W-1:0]  latch_divisor;
    logic [fbd_pkg::MV_W-1:0]  mul_value;
    logic [fbd_pkg::MV_W-1:0]  div_add_value;
    logic [fbd_pkg::PCT_W-1:0] error_percent;

    modport source (output valid, success, latch_divisor, mul_value, div_add_value,
                    error_percent, input ready);
    modport sink   (input valid, success, latch_divisor, mul_value, div_add_value,
                    error_percent, output ready);
endinterface

/* rtl/fbd_div.sv */
// ----------------------------------------------------------------------------
// fbd_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fbd_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [fbd_pkg::DIV_DEN_W-1:0] i_den,
    output logic [fbd_pkg::DIV_NUM_W-1:0] o_quo,
    output logic                          o_done,
    output logic                          o_busy
);
    import fbd_pkg::*;

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   trial_sub;
    logic                 ge;

    assign trial     = {r_rem, r_num[DIV_NUM_W-1]};
    assign ge        = trial >= {1'b0, r_den};
    assign trial_sub = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[DIV_NUM_W-2:0], ge};
                r_rem <= ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;
    assign o_busy = r_busy;

    `FBD_ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, i_start, !r_busy)
    `FBD_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)

endmodule

/* rtl/fbd_datapath.sv */
// ----------------------------------------------------------------------------
// fbd_datapath
// Config registers, candidate pair counters, best-pair tracking, result regs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbd_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [fbd_pkg::PORT_W-1:0]     i_port_number,
    input  logic [fbd_pkg::BAUD_W-1:0]     i_baud_rate,
    input  fbd_pkg::t_dp_cmd               i_cmd,
    output fbd_pkg::t_dp_stat              o_stat,
    output logic                           o_success,
    output logic [fbd_pkg::DL_W-1:0]       o_latch_divisor,
    output logic [fbd_pkg::MV_W-1:0]       o_mul_value,
    output logic [fbd_pkg::MV_W-1:0]       o_div_add_value,
    output logic [fbd_pkg::PCT_W-1:0]      o_error_percent
);
    import fbd_pkg::*;

    // configuration
    logic [CLK_W-1:0] r_core_clk;
    logic [SEL_W-1:0] r_div_sel;
    logic [ACC_W-1:0] r_acc_err;

    // request and search state
    logic [BAUD_W-1:0] r_baud;
    logic [CLK_W-1:0]  r_pclk;
    logic [MV_W-1:0]   r_m;
    logic [MV_W-1:0]   r_d;
    logic [31:0]       r_best_err;
    logic [DL_W-1:0]   r_best_dl;
    logic [MV_W-1:0]   r_best_m;
    logic [MV_W-1:0]   r_best_d;

    // results
    logic              r_success;
    logic [DL_W-1:0]   r_res_dl;
    logic [MV_W-1:0]   r_res_m;
    logic [MV_W-1:0]   r_res_d;
    logic [PCT_W-1:0]  r_res_pct;

    t_pclk_sel          sel;
    logic [CLK_W-1:0]   pclk_sel;

    logic [MV_W:0]      md_sum;
    logic [MV_W:0]      best_md_sum;
    logic               div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    logic               div_done;
    logic               div_busy;

    logic [31:0]        frac;
    logic               rnd_up;
    logic [28:0]        dl;
    logic [31:0]        err;
    logic               dl_ok;
    logic               better;

    logic [CLK_W-1:0]   rate;
    logic [CLK_W-1:0]   diff;
    logic               pct_sat;
    logic [PCT_W-1:0]   pct;

    always_comb begin
        sel = t_pclk_sel'(r_div_sel[2*i_port_number +: 2]);
        unique case (sel)
            PCLK_DIV1: pclk_sel = r_core_clk;
            PCLK_DIV2: pclk_sel = r_core_clk >> 1;
            PCLK_DIV8: pclk_sel = r_core_clk >> 3;
            default:   pclk_sel = r_core_clk >> 2;
        endcase
    end

    assign md_sum      = {1'b0, r_m} + {1'b0, r_d};
    assign best_md_sum = {1'b0, r_best_m} + {1'b0, r_best_d};

    // divider operand select
    always_comb begin
        div_start = i_cmd.start_pair | i_cmd.start_rate | i_cmd.start_pct;
        priority if (i_cmd.start_pair) begin
            div_num = {({4'd0, r_pclk} * {28'd0, r_m}), 28'd0};
            div_den = DIV_DEN_W'(r_baud) * DIV_DEN_W'(md_sum);
        end else if (i_cmd.start_rate) begin
            div_num = DIV_NUM_W'((r_pclk >> 4) * r_best_m);
            div_den = DIV_DEN_W'(r_best_dl) * DIV_DEN_W'(best_md_sum);
        end else begin
            div_num = DIV_NUM_W'({7'd0, diff} * {28'd0, PCT_SCALE});
            div_den = DIV_DEN_W'(r_baud);
        end
    end

    fbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done),
        .o_busy  (div_busy)
    );

    // candidate evaluation: round, range check, compare with best
    assign frac   = div_quo[31:0];
    assign rnd_up = frac > HALF_FRAC;
    assign dl     = {1'b0, div_quo[DIV_NUM_W-1:32]} + 29'(rnd_up);
    assign err    = rnd_up ? (32'd0 - frac) : frac;
    assign dl_ok  = (dl != '0) && (dl <= LATCH_MAX);
    assign better = dl_ok && (err < r_best_err);

    // final error percent
    assign rate    = div_quo[CLK_W-1:0];
    assign diff    = ({6'd0, r_baud} > rate) ? ({6'd0, r_baud} - rate)
                                             : (rate - {6'd0, r_baud});
    assign pct_sat = |div_quo[DIV_NUM_W-1:PCT_W];
    assign pct     = pct_sat ? PCT_SAT : div_quo[PCT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_clk <= CORE_CLK_RESET;
            r_div_sel  <= SEL_RESET;
            r_acc_err  <= ACC_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CORE_CLK: r_core_clk <= i_cfg_data[CLK_W-1:0];
                CFG_DIV_SEL:  r_div_sel  <= i_cfg_data[SEL_W-1:0];
                CFG_ACC_ERR:  r_acc_err  <= i_cfg_data[ACC_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dl <= '0;
            r_best_m  <= '0;
            r_best_d  <= '0;
        end else if (i_cmd.load) begin
            r_baud     <= i_baud_rate;
            r_pclk     <= pclk_sel;
            r_m        <= 4'd1;
            r_d        <= '0;
            r_best_err <= ERR_INIT;
            r_best_dl  <= '0;
            r_best_m   <= '0;
            r_best_d   <= '0;
        end else if (i_cmd.eval) begin
            if (better) begin
                r_best_err <= err;
                r_best_dl  <= dl[DL_W-1:0];
                r_best_m   <= r_m;
                r_best_d   <= r_d;
            end
            if (r_d == r_m - 1'b1) begin
                r_m <= r_m + 1'b1;
                r_d <= '0;
            end else begin
                r_d <= r_d + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            if (r_best_dl != '0) begin
                r_success <= pct < {1'b0, r_acc_err};
                r_res_dl  <= r_best_dl;
                r_res_m   <= r_best_m;
                r_res_d   <= r_best_d;
                r_res_pct <= pct;
            end else begin
                r_success <= 1'b0;
                r_res_dl  <= '0;
                r_res_m   <= '0;
                r_res_d   <= '0;
                r_res_pct <= '0;
            end
        end
    end

    assign o_stat.div_done  = div_done;
    assign o_stat.last_pair = (r_m == MUL_MAX) && (r_d == MUL_MAX - 1'b1);
    assign o_stat.exact_now = better && (err == '0);
    assign o_stat.found     = r_best_dl != '0;
    assign o_stat.baud_zero = i_baud_rate == '0;

    assign o_success       = r_success;
    assign o_latch_divisor = r_res_dl;
    assign o_mul_value     = r_res_m;
    assign o_div_add_value = r_res_d;
    assign o_error_percent = r_res_pct;

    `FBD_ASSERT_IMPL(a_best_legal, i_clk, i_rst_n, r_best_dl != '0,
        (r_best_m != '0) && (r_best_d < r_best_m))
    `FBD_ASSERT_IMPL(a_cmd_no_busy, i_clk, i_rst_n, div_start, !div_busy)

endmodule

/* rtl/fbd_ctrl.sv */
// ----------------------------------------------------------------------------
// fbd_ctrl
// Sequencer for the divisor search: pair loop, rate check, result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  fbd_pkg::t_dp_stat  i_stat,
    output fbd_pkg::t_dp_cmd   o_cmd
);
    import fbd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAIR,
        S_PAIR_WAIT,
        S_EVAL,
        S_CHECK,
        S_RATE_WAIT,
        S_PCT_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   in_xfer;
    logic   out_free;

    assign in_xfer  = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = in_xfer;
        o_cmd.start_pair = r_state == S_PAIR;
        o_cmd.eval       = r_state == S_EVAL;
        o_cmd.start_rate = (r_state == S_CHECK) && i_stat.found;
        o_cmd.start_pct  = (r_state == S_RATE_WAIT) && i_stat.div_done;
        o_cmd.load_res   = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= i_stat.baud_zero ? S_OUT : S_PAIR;
                    end
                end
                S_PAIR:      r_state <= S_PAIR_WAIT;
                S_PAIR_WAIT: begin
                    if (i_stat.div_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= (i_stat.exact_now || i_stat.last_pair) ? S_CHECK : S_PAIR;
                end
                S_CHECK: begin
                    r_state <= i_stat.found ? S_RATE_WAIT : S_OUT;
                end
                S_RATE_WAIT: begin
                    if (i_stat.div_done) begin
                        r_state <= S_PCT_WAIT;
                    end
                end
                S_PCT_WAIT: begin
                    if (i_stat.div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    `FBD_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, in_xfer, !o_in_ready)
    `FBD_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, o_cmd.load_res, r_out_valid)

endmodule

/* rtl/fractional_baud_divisor_search_core.sv */
// ----------------------------------------------------------------------------
// fractional_baud_divisor_search_core
// Searches UART fractional divider settings (latch divisor, mul, divadd)
// for a requested baud rate and reports the resulting error.
// ----------------------------------------------------------------------------
// One request at a time. Each candidate (mul, divadd) pair runs through
// the single shared 60-step restoring divider; a full search covers the
// 120 pairs and, if a pair was found, is followed by the rate recompute
// and percent divides; an exact match ends the search early, and a zero
// baud rate returns an all-zero result without using the divider.
// The input is ready again as soon as the result is in the output
// register, even if the sink has not taken it yet. Config writes
// (index 0 core clock, 1 packed per-port clock selects, 2 accepted error
// percent) must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module fractional_baud_divisor_search_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fbd_in_if.sink                         i_req,
    fbd_out_if.source                      o_res
);
    import fbd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: owns handshakes and the search loop
    fbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: config regs, pair counters, shared divider, result regs
    fbd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_port_number   (i_req.port_number),
        .i_baud_rate     (i_req.baud_rate),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_success       (o_res.success),
        .o_latch_divisor (o_res.latch_divisor),
        .o_mul_value     (o_res.mul_value),
        .o_div_add_value (o_res.div_add_value),
        .o_error_percent (o_res.error_percent)
    );

endmodule

/* tb/fractional_baud_divisor_search_core_tb.sv */
// ----------------------------------------------------------------------------
// fractional_baud_divisor_search_core_tb
// Self-checking bench for the fractional baud divisor search core: a table
// of directed requests, then random requests over several clock settings,
// each result checked field by field against a table entry or a bit-exact divisor predictor.
// ----------------------------------------------------------------------------
module fractional_baud_divisor_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbd_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOLD_CYCLES = 20_000;     // long sink stall, fills the core

    typedef struct packed {
        logic            success;
        logic [DL_W-1:0] latch_divisor;
        logic [MV_W-1:0] mul_value;
        logic [MV_W-1:0] div_add_value;
        logic [PCT_W-1:0] error_percent;
    } t_divisor_result;

    // Directed table row: typed expectation only where `typed` is set.
    typedef struct {
        logic [PORT_W-1:0] port;
        logic [BAUD_W-1:0] baud;
        bit                typed;
        t_divisor_result   want;
    } t_req_row;

    localparam t_divisor_result NO_PAIR = '0;
    localparam t_divisor_result EXACT_100 = '{1'b1, 17'd100, 4'd1, 4'd0, 8'd0};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fbd_in_if  req_if ();
    fbd_out_if res_if ();

    fractional_baud_divisor_search_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // Shadow copy of the configuration registers.
    logic [CLK_W-1:0] sh_core_clk;
    logic [SEL_W-1:0] sh_div_sel;
    logic [ACC_W-1:0] sh_acc_err;

    t_divisor_result pending_results[$];
    int unsigned     err_count;
    int unsigned     results_taken;
    longint unsigned cycle_count;

    t_req_row dir_rows[$];

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Bit-exact divisor search for one request under the shadow settings.
    function automatic t_divisor_result search_divisor(logic [PORT_W-1:0] port,
                                                       logic [BAUD_W-1:0] baud);
        t_divisor_result r;
        logic [1:0]  sel;
        logic [63:0] pclk, q, err, dl, best_err, best_dl, best_m, best_d;
        logic [63:0] rate, diff, pct;
        bit          hit;
        r = '0;
        sel = sh_div_sel[port*2 +: 2];
        case (t_pclk_sel'(sel))
            PCLK_DIV1: pclk = 64'(sh_core_clk);
            PCLK_DIV2: pclk = 64'(sh_core_clk >> 1);
            PCLK_DIV8: pclk = 64'(sh_core_clk >> 3);
            default:   pclk = 64'(sh_core_clk >> 2);
        endcase
        if (baud == 0) return r;
        best_err = 64'hFFFF_FFFF;
        best_dl = 0; best_m = 0; best_d = 0;
        hit = 1'b0;
        for (int m = 1; m <= 15 && !hit; m++) begin
            for (int d = 0; d < m && !hit; d++) begin
                q = ((pclk << 28) * 64'(m)) / (64'(baud) * 64'(m + d));
                err = q & 64'hFFFF_FFFF;
                dl = q >> 32;
                if (err > 64'h8000_0000) begin
                    err = 64'h1_0000_0000 - err;
                    dl++;
                end
                if (dl >= 1 && dl <= 65536 && err < best_err) begin
                    best_err = err;
                    best_dl = dl; best_m = m; best_d = d;
                    hit = (err == 0);
                end
            end
        end
        if (best_dl == 0) return r;
        rate = ((pclk >> 4) * best_m) / (best_dl * (best_m + best_d));
        diff = (baud > rate) ? 64'(baud) - rate : rate - 64'(baud);
        pct = (diff * 100) / 64'(baud);
        if (pct > 255) pct = 255;
        r.success       = (pct < 64'(sh_acc_err));
        r.latch_divisor = best_dl[DL_W-1:0];
        r.mul_value     = best_m[MV_W-1:0];
        r.div_add_value = best_d[MV_W-1:0];
        r.error_percent = pct[PCT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
        err_count++;
    endtask

    // Register write; the shadow copy follows the same masking.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CORE_CLK: sh_core_clk = data[CLK_W-1:0];
            CFG_DIV_SEL:  sh_div_sel  = data[SEL_W-1:0];
            CFG_ACC_ERR:  sh_acc_err  = data[ACC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [CLK_W-1:0] clk_hz, logic [SEL_W-1:0] sel,
                              logic [ACC_W-1:0] acc);
        write_reg(CFG_CORE_CLK, CFG_DATA_W'(clk_hz));
        write_reg(CFG_DIV_SEL, CFG_DATA_W'(sel));
        write_reg(CFG_ACC_ERR, CFG_DATA_W'(acc));
    endtask

    // Idle between phases: only once every result is back.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // One request transfer; valid stays high across back-to-back transfers.
    task automatic send_request(logic [PORT_W-1:0] port, logic [BAUD_W-1:0] baud,
                                bit typed, t_divisor_result want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.port_number <= port;
        req_if.baud_rate   <= baud;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(typed ? want : search_divisor(port, baud));
    endtask

    function automatic logic [BAUD_W-1:0] random_baud();
        int roll;
        logic [BAUD_W-1:0] std_rates[10] = '{300, 1200, 2400, 9600, 19200, 38400,
                                             57600, 115200, 460800, 921600};
        roll = $urandom_range(0, 99);
        if (roll < 50) return std_rates[$urandom_range(0, 9)];
        if (roll < 65) return BAUD_W'($urandom_range(1, 2000));
        return BAUD_W'($urandom_range(1, (1 << BAUD_W) - 1));
    endfunction

    // Result sink: random stalls, plus one long hold to back up the core.
    initial begin : result_sink
        int  stall;
        bit  held;
        t_divisor_result got, want;
        stall = 0;
        held = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.success, res_if.latch_divisor, res_if.mul_value,
                        res_if.div_add_value, res_if.error_percent};
                results_taken++;
                if (pending_results.size() == 0) begin
                    $display("[%0t] result transfer with nothing expected", $realtime);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.success != want.success)
                        report_mismatch("success", want.success, got.success);
                    if (got.latch_divisor != want.latch_divisor)
                        report_mismatch("latch_divisor", want.latch_divisor,
                                        got.latch_divisor);
                    if (got.mul_value != want.mul_value)
                        report_mismatch("mul_value", want.mul_value, got.mul_value);
                    if (got.div_add_value != want.div_add_value)
                        report_mismatch("div_add_value", want.div_add_value,
                                        got.div_add_value);
                    if (got.error_percent != want.error_percent)
                        report_mismatch("error_percent", want.error_percent,
                                        got.error_percent);
                end
            end
            if (!held && results_taken == 30) begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        logic [CLK_W-1:0] clk_hz;
        err_count = 0;
        results_taken = 0;
        cycle_count = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_CORE_CLK;
        i_cfg_data   <= '0;
        req_if.valid <= 1'b0;
        req_if.port_number <= '0;
        req_if.baud_rate   <= '0;
        sh_core_clk = CORE_CLK_RESET;
        sh_div_sel  = SEL_RESET;
        sh_acc_err  = ACC_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, reset settings: every port at 25 MHz peripheral clock.
        dir_rows = '{
            '{2'd0, 22'd0,       1'b1, NO_PAIR},     // zero baud rate
            '{2'd3, 22'd1,       1'b1, NO_PAIR},     // divisor above range
            '{2'd1, 22'd4000000, 1'b1, NO_PAIR},     // divisor below one
            '{2'd2, 22'h3FFFFF,  1'b1, NO_PAIR},
            '{2'd0, 22'd15625,   1'b1, EXACT_100},   // exact match, stops at mul 1
            '{2'd1, 22'd9600,    1'b0, NO_PAIR},
            '{2'd2, 22'd115200,  1'b0, NO_PAIR},
            '{2'd3, 22'd19200,   1'b0, NO_PAIR},
            '{2'd0, 22'd38400,   1'b0, NO_PAIR},
            '{2'd1, 22'd57600,   1'b0, NO_PAIR},
            '{2'd2, 22'd230400,  1'b0, NO_PAIR},
            '{2'd3, 22'd921600,  1'b0, NO_PAIR},
            '{2'd0, 22'd24,      1'b0, NO_PAIR},     // top of divisor range
            '{2'd1, 22'd23,      1'b0, NO_PAIR}      // needs a fraction to fit
        };
        foreach (dir_rows[i])
            send_request(dir_rows[i].port, dir_rows[i].baud, dir_rows[i].typed,
                         dir_rows[i].want);
        drain();

        // One clock select per port, 200 MHz core clock, success never possible.
        set_config(28'd200000000, {PCLK_DIV8, PCLK_DIV2, PCLK_DIV1, PCLK_DIV4}, 7'd0);
        write_reg(CFG_NONE, 28'hFFF_FFFF);       // unmapped index, ignored
        for (int p = 0; p < 4; p++) send_request(PORT_W'(p), 22'd115200, 1'b0, NO_PAIR);
        send_request(2'd1, 22'h3FFFFF, 1'b0, NO_PAIR);
        drain();

        // Zero core clock: no pair can fit.
        set_config(28'd0, 8'hFF, 7'd100);
        send_request(2'd2, 22'd9600, 1'b1, NO_PAIR);
        send_request(2'd1, 22'd1, 1'b1, NO_PAIR);
        drain();

        // Random phases: extremes first, then random settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: clk_hz = 28'd1;
                1: clk_hz = 28'd200000000;
                2: clk_hz = 28'hFFF_FFFF;
                default: clk_hz = CLK_W'($urandom_range(1000000, 200000000));
            endcase
            set_config(clk_hz, SEL_W'($urandom),
                       (ph == 1) ? 7'd100 : (ph == 2) ? 7'h7F
                                  : ACC_W'($urandom_range(0, 100)));
            for (int n = 0; n < ((ph == 0) ? 6 : 15); n++)
                send_request(PORT_W'($urandom), random_baud(), 1'b0, NO_PAIR);
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
